// ----- rtl/aga_pkg.sv -----
// Shared types, constants and state codes for the gravity autoscale block.
package aga_pkg;

    // Number of calibration items averaged into one scale.
    localparam int CAL_COUNT = 64;

    // Widths of the stored state and the arithmetic.
    localparam int AXIS_W  = 17;
    localparam int SUM_W   = 27;
    localparam int SEEN_W  = 11;
    localparam int SCALE_W = 24;
    localparam int ACCEL_W = 32;
    localparam int PROD_W  = 2 * SUM_W;
    localparam int SQ_W    = 52;
    localparam int RAD_W   = SQ_W + 18;
    localparam int REM_W   = 38;
    localparam int ROOT_W  = 35;
    localparam int CNT_W   = 6;

    // Iteration counts of the shared unit.
    localparam int ROOT_STEPS = 35;
    localparam int DIV_STEPS  = 32;

    localparam logic [SCALE_W-1:0] NOMINAL_RESET = 24'd5248;
    localparam logic [SCALE_W-1:0] SCALE_MAX     = 24'hFF_FFFF;
    localparam logic [ACCEL_W-1:0] ACCEL_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [ACCEL_W-1:0] ACCEL_NEG_SAT = 32'h8000_0000;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_DATA   = 2'd1,
        STAT_CAL_TAKEN = 2'd2,
        STAT_CAL_DONE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_ROOT,
        ST_CAL_END,
        ST_DIV_SETUP,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic               func;
        logic               drdy;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [ACCEL_W-1:0]  accel_x;
        logic signed [ACCEL_W-1:0]  accel_y;
        logic signed [ACCEL_W-1:0]  accel_z;
        logic        [SCALE_W-1:0]  scale_now;
    } out_item_t;

endpackage

// ----- rtl/accel_gravity_autoscale.sv -----
// Top level: accelerometer axis remap, one-g calibration and scaling to g.
//
// Input items arrive on s_valid/s_ready/s_item, one raw three-axis sample each.
// Every item gives exactly one result item on m_valid/m_ready/m_item.
// cfg_we/cfg_wdata write the nominal scale (Q16.8 counts per g), used until a
// calibration run has finished; write it only while the block is idle.
// The block works on one item at a time; s_ready is high only when idle.
// Work between acceptance and m_valid, on the shared subtract/compare unit:
//   calibration sample taken or no data: none;
//   calibration finished: 3 squares on the multiplier, then a
//   35-step square root;
//   measure sample: up to three 32-step divisions, one per axis.
// The next item can be accepted the cycle after the result is loaded into the
// output register, even while that result still waits for m_ready.
// If the receiver stalls and the output register is full, a finished item
// waits inside the block and s_ready stays low.
// Reset (aresetn low, synchronous) clears the sums, the calibration and the
// output valid, and restores the nominal scale to 20.5 counts per g.
module accel_gravity_autoscale (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  aga_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output aga_pkg::out_item_t              m_item,
    input  logic                            cfg_we,
    input  logic [aga_pkg::SCALE_W-1:0]     cfg_wdata
);

    aga_pkg::fsm_state_t state_reg, state_next;

    logic [aga_pkg::SCALE_W-1:0]        nominal_reg, nominal_next;
    logic signed [aga_pkg::SUM_W-1:0]   sum_reg [3];
    logic signed [aga_pkg::SUM_W-1:0]   sum_next [3];
    logic [aga_pkg::SEEN_W-1:0]         cal_seen_reg, cal_seen_next;
    logic [aga_pkg::SCALE_W-1:0]        cal_scale_reg, cal_scale_next;
    logic                               calibrated_reg, calibrated_next;

    logic signed [aga_pkg::AXIS_W-1:0]  v_reg [3];
    logic signed [aga_pkg::AXIS_W-1:0]  v_next [3];
    logic [aga_pkg::ACCEL_W-1:0]        accel_reg [3];
    logic [aga_pkg::ACCEL_W-1:0]        accel_next [3];
    logic [aga_pkg::SCALE_W-1:0]        scale_reg, scale_next;
    logic [1:0]                         axis_reg, axis_next;
    logic [aga_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [aga_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [aga_pkg::ACCEL_W-1:0]        quo_reg, quo_next;
    logic [aga_pkg::ACCEL_W-1:0]        dshift_reg, dshift_next;
    logic [aga_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [aga_pkg::SQ_W-1:0]           acc_reg, acc_next;
    logic [aga_pkg::RAD_W-1:0]          nshift_reg, nshift_next;
    logic [aga_pkg::ROOT_W-1:0]         root_reg, root_next;
    aga_pkg::status_t                   status_reg, status_next;
    logic                               out_valid_reg, out_valid_next;
    aga_pkg::out_item_t                 out_item_reg, out_item_next;

    logic                               accept;
    logic                               out_load;
    logic                               cal_last;
    logic signed [aga_pkg::AXIS_W-1:0]  in_v [3];
    logic [aga_pkg::SEEN_W-1:0]         seen_inc;
    logic [aga_pkg::SUM_W-1:0]          sum_mag;
    logic signed [aga_pkg::AXIS_W-1:0]  v_cur;
    logic                               v_neg;
    logic [15:0]                        v_mag;
    logic [aga_pkg::SQ_W-1:0]           acc_sum;
    logic [aga_pkg::ROOT_W-1:0]         root_div;
    logic [aga_pkg::SCALE_W-1:0]        scale_in_use;
    logic [aga_pkg::ACCEL_W-1:0]        div_result;
    logic [aga_pkg::REM_W-1:0]          sub_a, sub_b;
    logic [aga_pkg::REM_W:0]            sub_diff;
    logic                               sub_ge;

    // Handshake and remap of the incoming sample to board axes.
    assign s_ready  = (state_reg == aga_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == aga_pkg::ST_DONE) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    assign in_v[0]  = aga_pkg::AXIS_W'(s_item.raw_y);
    assign in_v[1]  = -aga_pkg::AXIS_W'(s_item.raw_x);
    assign in_v[2]  = aga_pkg::AXIS_W'(s_item.raw_z);
    assign seen_inc = cal_seen_reg + 1'b1;
    assign cal_last = (seen_inc >= aga_pkg::SEEN_W'(aga_pkg::CAL_COUNT));

    assign scale_in_use = calibrated_reg ? cal_scale_reg : nominal_reg;

    // Magnitudes of the selected sum and of the selected axis.
    assign sum_mag = sum_reg[axis_reg][aga_pkg::SUM_W-1] ? aga_pkg::SUM_W'(-sum_reg[axis_reg])
                                                         : aga_pkg::SUM_W'(sum_reg[axis_reg]);
    assign v_cur   = v_reg[axis_reg];
    assign v_neg   = v_cur[aga_pkg::AXIS_W-1];
    assign v_mag   = v_neg ? 16'(-v_cur) : 16'(v_cur);
    assign acc_sum = acc_reg + prod_reg[aga_pkg::SQ_W-1:0];
    assign root_div = root_reg / aga_pkg::CAL_COUNT;

    // Shared subtract/compare unit: overflow check, divide step and root step.
    always_comb begin
        case (state_reg)
            aga_pkg::ST_DIV_SETUP: begin
                sub_a = aga_pkg::REM_W'(v_mag);
                sub_b = aga_pkg::REM_W'({scale_reg, 8'b0});
            end
            aga_pkg::ST_DIV_STEP: begin
                sub_a = aga_pkg::REM_W'({rem_reg[aga_pkg::SCALE_W-1:0],
                                         dshift_reg[aga_pkg::ACCEL_W-1]});
                sub_b = aga_pkg::REM_W'(scale_reg);
            end
            aga_pkg::ST_ROOT: begin
                sub_a = {rem_reg[aga_pkg::REM_W-3:0], nshift_reg[aga_pkg::RAD_W-1 -: 2]};
                sub_b = aga_pkg::REM_W'({root_reg, 2'b01});
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[aga_pkg::REM_W];

    // Signed saturation of the quotient magnitude.
    always_comb begin
        if (v_neg) begin
            if (quo_reg > aga_pkg::ACCEL_NEG_SAT) begin
                div_result = aga_pkg::ACCEL_NEG_SAT;
            end else begin
                div_result = -quo_reg;
            end
        end else begin
            if (quo_reg[aga_pkg::ACCEL_W-1]) begin
                div_result = aga_pkg::ACCEL_POS_SAT;
            end else begin
                div_result = quo_reg;
            end
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aga_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_item.func) begin
                        state_next = cal_last ? aga_pkg::ST_SQ_MUL : aga_pkg::ST_DONE;
                    end else if (!s_item.drdy) begin
                        state_next = aga_pkg::ST_DONE;
                    end else begin
                        state_next = aga_pkg::ST_DIV_SETUP;
                    end
                end
            end
            aga_pkg::ST_SQ_MUL: begin
                state_next = aga_pkg::ST_SQ_ACC;
            end
            aga_pkg::ST_SQ_ACC: begin
                state_next = (axis_reg == 2'd2) ? aga_pkg::ST_ROOT : aga_pkg::ST_SQ_MUL;
            end
            aga_pkg::ST_ROOT: begin
                if (cnt_reg == aga_pkg::CNT_W'(aga_pkg::ROOT_STEPS - 1)) begin
                    state_next = aga_pkg::ST_CAL_END;
                end
            end
            aga_pkg::ST_CAL_END: begin
                state_next = aga_pkg::ST_DONE;
            end
            aga_pkg::ST_DIV_SETUP: begin
                if (v_mag != '0 && !sub_ge) begin
                    state_next = aga_pkg::ST_DIV_STEP;
                end else if (axis_reg == 2'd2) begin
                    state_next = aga_pkg::ST_DONE;
                end
            end
            aga_pkg::ST_DIV_STEP: begin
                if (cnt_reg == aga_pkg::CNT_W'(aga_pkg::DIV_STEPS - 1)) begin
                    state_next = aga_pkg::ST_DIV_END;
                end
            end
            aga_pkg::ST_DIV_END: begin
                state_next = (axis_reg == 2'd2) ? aga_pkg::ST_DONE : aga_pkg::ST_DIV_SETUP;
            end
            aga_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = aga_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aga_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output values for each state.
    always_comb begin
        nominal_next    = cfg_we ? cfg_wdata : nominal_reg;
        sum_next        = sum_reg;
        cal_seen_next   = cal_seen_reg;
        cal_scale_next  = cal_scale_reg;
        calibrated_next = calibrated_reg;
        v_next          = v_reg;
        accel_next      = accel_reg;
        scale_next      = scale_reg;
        axis_next       = axis_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dshift_next     = dshift_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        nshift_next     = nshift_reg;
        root_next       = root_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_item_next   = out_item_reg;

        case (state_reg)
            aga_pkg::ST_IDLE: begin
                if (accept) begin
                    v_next     = in_v;
                    axis_next  = '0;
                    scale_next = scale_in_use;
                    accel_next = '{default: '0};
                    acc_next   = '0;
                    if (s_item.func) begin
                        for (int k = 0; k < 3; k++) begin
                            sum_next[k] = sum_reg[k] + aga_pkg::SUM_W'(in_v[k]);
                        end
                        // The run counter restarts as soon as the last item of a run is in.
                        cal_seen_next = cal_last ? '0 : seen_inc;
                        status_next = cal_last ? aga_pkg::STAT_CAL_DONE
                                               : aga_pkg::STAT_CAL_TAKEN;
                    end else if (!s_item.drdy) begin
                        status_next = aga_pkg::STAT_NO_DATA;
                    end else begin
                        status_next = aga_pkg::STAT_OK;
                    end
                end
            end
            aga_pkg::ST_SQ_MUL: begin
                prod_next = sum_mag * sum_mag;
            end
            aga_pkg::ST_SQ_ACC: begin
                acc_next  = acc_sum;
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2) begin
                    nshift_next = {2'b00, acc_sum, 16'b0};
                    rem_next    = '0;
                    root_next   = '0;
                    cnt_next    = '0;
                end
            end
            aga_pkg::ST_ROOT: begin
                rem_next    = sub_ge ? sub_diff[aga_pkg::REM_W-1:0] : sub_a;
                root_next   = {root_reg[aga_pkg::ROOT_W-2:0], sub_ge};
                nshift_next = {nshift_reg[aga_pkg::RAD_W-3:0], 2'b00};
                cnt_next    = cnt_reg + 1'b1;
            end
            aga_pkg::ST_CAL_END: begin
                if (root_div > aga_pkg::ROOT_W'(aga_pkg::SCALE_MAX)) begin
                    cal_scale_next = aga_pkg::SCALE_MAX;
                end else begin
                    cal_scale_next = root_div[aga_pkg::SCALE_W-1:0];
                end
                calibrated_next = 1'b1;
                sum_next        = '{default: '0};
                cal_seen_next   = '0;
            end
            aga_pkg::ST_DIV_SETUP: begin
                if (v_mag == '0) begin
                    accel_next[axis_reg] = '0;
                    axis_next = axis_reg + 2'd1;
                end else if (sub_ge) begin
                    // Quotient needs more than 32 bits, or the scale is zero.
                    accel_next[axis_reg] = v_neg ? aga_pkg::ACCEL_NEG_SAT
                                                 : aga_pkg::ACCEL_POS_SAT;
                    axis_next = axis_reg + 2'd1;
                end else begin
                    rem_next    = aga_pkg::REM_W'(v_mag[15:8]);
                    dshift_next = {v_mag[7:0], 24'b0};
                    quo_next    = '0;
                    cnt_next    = '0;
                end
            end
            aga_pkg::ST_DIV_STEP: begin
                rem_next    = sub_ge ? sub_diff[aga_pkg::REM_W-1:0] : sub_a;
                quo_next    = {quo_reg[aga_pkg::ACCEL_W-2:0], sub_ge};
                dshift_next = {dshift_reg[aga_pkg::ACCEL_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
            end
            aga_pkg::ST_DIV_END: begin
                accel_next[axis_reg] = div_result;
                axis_next = axis_reg + 2'd1;
            end
            aga_pkg::ST_DONE: begin
                if (out_load) begin
                    out_valid_next          = 1'b1;
                    out_item_next.status    = status_reg;
                    out_item_next.accel_x   = accel_reg[0];
                    out_item_next.accel_y   = accel_reg[1];
                    out_item_next.accel_z   = accel_reg[2];
                    out_item_next.scale_now = scale_in_use;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= aga_pkg::ST_IDLE;
            nominal_reg    <= aga_pkg::NOMINAL_RESET;
            sum_reg        <= '{default: '0};
            cal_seen_reg   <= '0;
            cal_scale_reg  <= '0;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            nominal_reg    <= nominal_next;
            sum_reg        <= sum_next;
            cal_seen_reg   <= cal_seen_next;
            cal_scale_reg  <= cal_scale_next;
            calibrated_reg <= calibrated_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge aclk) begin
        v_reg        <= v_next;
        accel_reg    <= accel_next;
        scale_reg    <= scale_next;
        axis_reg     <= axis_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dshift_reg   <= dshift_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        nshift_reg   <= nshift_next;
        root_reg     <= root_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    // The run counter wraps before it reaches the run length.
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_seen_reg < aga_pkg::SEEN_W'(aga_pkg::CAL_COUNT))
        else $error("calibration count reached run length");

    // One item at a time: no acceptance right after an acceptance.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while an item is in work");

    // The divide remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aga_pkg::ST_DIV_STEP) |-> (rem_reg < aga_pkg::REM_W'(scale_reg)))
        else $error("divider remainder out of range");

    // A finished calibration leaves the calibrated scale in use.
    a_cal_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_item_reg.status == aga_pkg::STAT_CAL_DONE)
            |-> (calibrated_reg && out_item_reg.scale_now == cal_scale_reg))
        else $error("calibration result without calibrated scale");

    // Items with no data or with a calibration sample taken carry zero acceleration.
    a_zero_accel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_item_reg.status == aga_pkg::STAT_NO_DATA ||
                           out_item_reg.status == aga_pkg::STAT_CAL_TAKEN))
            |-> (out_item_reg.accel_x == '0 && out_item_reg.accel_y == '0 &&
                 out_item_reg.accel_z == '0))
        else $error("nonzero acceleration on an item without a measurement");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the accelerometer gravity autoscale block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600_000;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_CYCLES  = 120;

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    aga_pkg::in_item_t            s_item    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    aga_pkg::out_item_t           m_item;
    logic                         cfg_we    = 1'b0;
    logic [aga_pkg::SCALE_W-1:0]  cfg_wdata = '0;

    // Samples waiting to be sent, and readings awaited from the block.
    aga_pkg::in_item_t  samples_to_send[$];
    aga_pkg::out_item_t awaited_readings[$];

    // Counters and traffic settings used by the sender, receiver, monitor and sequence.
    int sent_cnt     = 0;
    int accepted_cnt = 0;
    int pushed_cnt   = 0;
    int gen_cal_cnt  = 0;
    int mismatches   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap      = 0;
    int snk_stall    = 0;
    int cycle_cnt    = 0;

    // Predictor state: gravity sums, calibration progress and the scales.
    longint                      grav_sum_x   = 0;
    longint                      grav_sum_y   = 0;
    longint                      grav_sum_z   = 0;
    int                          grav_taken   = 0;
    logic [aga_pkg::SCALE_W-1:0] fitted_scale = '0;
    bit                          fitted       = 1'b0;
    logic [aga_pkg::SCALE_W-1:0] nominal_cfg  = aga_pkg::NOMINAL_RESET;

    accel_gravity_autoscale dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Floor of the square root of a 64-bit value, one result bit at a time.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // One board axis in g, Q15.16, truncated toward zero and saturated.
    function automatic logic signed [aga_pkg::ACCEL_W-1:0] axis_in_g(
        longint v, logic [aga_pkg::SCALE_W-1:0] sc);
        longint q;
        longint d;
        if (sc == '0) begin
            if (v > 0) return aga_pkg::ACCEL_POS_SAT;
            if (v < 0) return aga_pkg::ACCEL_NEG_SAT;
            return '0;
        end
        d = sc;
        q = (v * 64'sd16777216) / d;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // Reading the block should give for one accepted sample; updates the state.
    function automatic aga_pkg::out_item_t scaled_reading(aga_pkg::in_item_t it);
        aga_pkg::out_item_t          r;
        longint                      bx;
        longint                      by;
        longint                      bz;
        longint unsigned             sq;
        longint unsigned             m;
        logic [aga_pkg::SCALE_W-1:0] sc;
        bx = longint'(it.raw_y);
        by = -longint'(it.raw_x);
        bz = longint'(it.raw_z);
        r = '0;
        if (it.func) begin
            grav_sum_x += bx;
            grav_sum_y += by;
            grav_sum_z += bz;
            grav_taken++;
            if (grav_taken >= aga_pkg::CAL_COUNT) begin
                sq = grav_sum_x * grav_sum_x + grav_sum_y * grav_sum_y
                   + grav_sum_z * grav_sum_z;
                m = root_floor(sq << 16) / aga_pkg::CAL_COUNT;
                if (m > aga_pkg::SCALE_MAX) m = aga_pkg::SCALE_MAX;
                fitted_scale = m[aga_pkg::SCALE_W-1:0];
                fitted       = 1'b1;
                grav_sum_x   = 0;
                grav_sum_y   = 0;
                grav_sum_z   = 0;
                grav_taken   = 0;
                r.status     = aga_pkg::STAT_CAL_DONE;
            end else begin
                r.status = aga_pkg::STAT_CAL_TAKEN;
            end
        end else if (!it.drdy) begin
            r.status = aga_pkg::STAT_NO_DATA;
        end else begin
            sc = fitted ? fitted_scale : nominal_cfg;
            r.status  = aga_pkg::STAT_OK;
            r.accel_x = axis_in_g(bx, sc);
            r.accel_y = axis_in_g(by, sc);
            r.accel_z = axis_in_g(bz, sc);
        end
        r.scale_now = fitted ? fitted_scale : nominal_cfg;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Axis value biased toward the extremes and small counts.
    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
            4, 5, 6: return 16'($urandom());
            default: return clamp16(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    task automatic add_sample(bit func, bit rdy, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z);
        aga_pkg::in_item_t it;
        it.func  = func;
        it.drdy  = rdy;
        it.raw_x = x;
        it.raw_y = y;
        it.raw_z = z;
        samples_to_send.push_back(it);
        pushed_cnt++;
        if (func) gen_cal_cnt++;
    endtask

    task automatic add_measure();
        add_sample(1'b0, $urandom_range(0, 99) < 85, rand_axis(), rand_axis(), rand_axis());
    endtask

    // Finish the current calibration run: kind 0 noisy gravity vector,
    // kind 1 all zero, kind 2 all axes at the negative extreme.
    task automatic cal_run(int kind, int mix_pct);
        int gx;
        int gy;
        int gz;
        if ($urandom_range(0, 3) == 0) begin
            gx = int'(rand_axis());
            gy = int'(rand_axis());
            gz = int'(rand_axis());
        end else begin
            gx = int'($urandom_range(0, 4000)) - 2000;
            gy = int'($urandom_range(0, 4000)) - 2000;
            gz = int'($urandom_range(0, 4000)) - 2000;
        end
        do begin
            if (gen_cal_cnt % aga_pkg::CAL_COUNT != 0 && $urandom_range(0, 99) < mix_pct) begin
                if ($urandom_range(0, 1) != 0)
                    add_sample(1'b0, $urandom_range(0, 99) < 90,
                               clamp16(gx + int'($urandom_range(0, 60)) - 30),
                               clamp16(gy + int'($urandom_range(0, 60)) - 30),
                               clamp16(gz + int'($urandom_range(0, 60)) - 30));
                else
                    add_measure();
            end else if (kind == 1) begin
                add_sample(1'b1, $urandom_range(0, 1), '0, '0, '0);
            end else if (kind == 2) begin
                add_sample(1'b1, $urandom_range(0, 1), 16'sh8000, 16'sh8000, 16'sh8000);
            end else begin
                add_sample(1'b1, $urandom_range(0, 1),
                           clamp16(gx + int'($urandom_range(0, 40)) - 20),
                           clamp16(gy + int'($urandom_range(0, 40)) - 20),
                           clamp16(gz + int'($urandom_range(0, 40)) - 20));
            end
        end while (gen_cal_cnt % aga_pkg::CAL_COUNT != 0);
    endtask

    // Block until every queued sample is taken and every reading has come.
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || accepted_cnt != sent_cnt
               || awaited_readings.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_nominal(logic [aga_pkg::SCALE_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        nominal_cfg = v;
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Sender: new item or idle burst at the falling edge, held until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && accepted_cnt != sent_cnt) begin
            // Item still waiting for s_ready.
        end else if (src_gap > 0) begin
            src_gap--;
            s_valid <= 1'b0;
        end else if (samples_to_send.size() == 0) begin
            s_valid <= 1'b0;
        end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            src_gap = $urandom_range(0, 8);
            s_valid <= 1'b0;
        end else begin
            s_item  <= samples_to_send.pop_front();
            s_valid <= 1'b1;
            sent_cnt++;
        end
    end

    // Receiver: random stall bursts on m_ready.
    always @(negedge aclk) begin
        if (snk_stall > 0) begin
            snk_stall--;
            m_ready <= 1'b0;
        end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            snk_stall = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted item, check each accepted result.
    always @(posedge aclk) begin
        aga_pkg::out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            awaited_readings.push_back(scaled_reading(s_item));
            accepted_cnt++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_readings.size() == 0) begin
                $error("result with no item awaiting it: status %0d", m_item.status);
                mismatches++;
            end else begin
                want = awaited_readings.pop_front();
                check_field("status", want.status, m_item.status);
                check_field("accel_x", want.accel_x, m_item.accel_x);
                check_field("accel_y", want.accel_y, m_item.accel_y);
                check_field("accel_z", want.accel_z, m_item.accel_z);
                check_field("scale_now", want.scale_now, m_item.scale_now);
            end
        end
    end

    // Watchdog on total run length.
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[accel_gravity_autoscale] ERROR");
        $finish;
    end

    // Test sequence.
    initial begin
        int rand_base;
        int phase_mark;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 15;
        snk_idle_pct = 15;

        // Directed samples at the reset scale: extremes, no data, partial calibration.
        add_sample(1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0);
        add_sample(1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        add_sample(1'b0, 1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000);
        add_sample(1'b0, 1'b1, 16'sd1, -16'sd1, -16'sd1);
        add_sample(1'b0, 1'b0, -16'sd1, -16'sd1, -16'sd1);
        add_sample(1'b0, 1'b0, 16'sh7FFF, 16'sh8000, 16'sd1234);
        add_sample(1'b1, 1'b0, 16'sd100, -16'sd200, 16'sd300);
        add_sample(1'b1, 1'b1, -16'sd150, 16'sd250, 16'sd20);
        add_sample(1'b0, 1'b1, -16'sd20, 16'sd21, 16'sd41);
        wait_drained();

        // Zero nominal scale saturates by sign.
        write_nominal('0);
        add_sample(1'b0, 1'b1, 16'sd5, -16'sd5, 16'sd0);
        add_sample(1'b0, 1'b1, 16'sh8000, 16'sh7FFF, 16'sd0);
        add_sample(1'b0, 1'b0, 16'sd3, 16'sd3, 16'sd3);
        wait_drained();

        // Smallest and largest nominal scales.
        write_nominal(24'd1);
        add_sample(1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 16'sd1);
        add_sample(1'b0, 1'b1, 16'sd1, -16'sd1, 16'sd0);
        wait_drained();
        write_nominal(aga_pkg::SCALE_MAX);
        add_sample(1'b0, 1'b1, 16'sh8000, 16'sh7FFF, 16'sd12345);
        add_sample(1'b0, 1'b1, 16'sd1, 16'sd1, 16'sd1);
        wait_drained();

        // Random measures under several nominal scales, before any calibration.
        rand_base = pushed_cnt;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_nominal(24'($urandom_range(1, 255)));
                1: write_nominal(24'($urandom_range(1, 24'hFF_FFFF)));
                2: write_nominal(aga_pkg::SCALE_MAX);
                default: write_nominal(aga_pkg::NOMINAL_RESET);
            endcase
            src_idle_pct = (p == 0) ? 0 : 10 * p;
            snk_idle_pct = (p == 1) ? 0 : 35 - 10 * p;
            repeat (40) add_measure();
            wait_drained();
        end

        // Calibration: a noisy run, an all-zero run, then an extreme run.
        src_idle_pct = 20;
        snk_idle_pct = 20;
        cal_run(0, 20);
        cal_run(1, 15);
        cal_run(2, 15);
        wait_drained();

        // Random mix of calibration runs, measure bursts and noise.
        phase_mark = pushed_cnt + 150;
        while (pushed_cnt - rand_base < RANDOM_ITEMS) begin
            // No idling on either side over the last part of the run.
            if (RANDOM_ITEMS - (pushed_cnt - rand_base) < 200) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                    cal_run(0, $urandom_range(5, 40));
                14, 15, 16:
                    repeat ($urandom_range(5, 30)) add_measure();
                default:
                    repeat ($urandom_range(1, 20))
                        add_sample($urandom_range(0, 1), $urandom_range(0, 1),
                                   16'($urandom()), 16'($urandom()), 16'($urandom()));
            endcase
            if (pushed_cnt >= phase_mark) begin
                // Sender holds off until every reading is back, then a new setting.
                wait_drained();
                write_nominal(24'($urandom_range(0, 24'hFF_FFFF)));
                if (RANDOM_ITEMS - (pushed_cnt - rand_base) < 200) begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end else begin
                    src_idle_pct = 10 * $urandom_range(0, 4);
                    snk_idle_pct = 10 * $urandom_range(0, 4);
                end
                phase_mark = pushed_cnt + 150;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited_readings.size() != 0) begin
            $error("%0d readings never arrived", awaited_readings.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[accel_gravity_autoscale] OK");
        else
            $display("[accel_gravity_autoscale] ERROR");
        $finish;
    end

endmodule
